// ===== rtl/whp_pkg.sv =====
package whp_pkg;

	// Chunk tags, big-endian as read from the stream
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [15:0] FMT_PCM   = 16'h0001;
	localparam logic [15:0] FMT_FLOAT = 16'h0003;
	localparam logic [15:0] FMT_EXT   = 16'hFFFE;

	// Defaults before a fmt chunk is seen
	localparam logic [15:0] DEF_CHANNELS = 16'd1;
	localparam logic [31:0] DEF_RATE     = 32'd44100;
	localparam logic [15:0] DEF_BITS     = 16'd8;

	// The extensible fmt remainder must exceed this to carry valid bits and subformat
	localparam logic [31:0] EXT_MIN_LEFT = 32'd9;

	localparam int unsigned DIV_STEPS = 32;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_NOT_RIFF   = 3'd1;
	localparam status_t ST_NOT_WAVE   = 3'd2;
	localparam status_t ST_BAD_FORMAT = 3'd3;
	localparam status_t ST_NO_DATA    = 3'd4;
	localparam status_t ST_TRUNCATED  = 3'd5;
	localparam status_t ST_ZERO_FRAME = 3'd6;

	typedef enum logic [3:0] {
		PH_RIFF,
		PH_RSIZE,
		PH_WAVE,
		PH_CID,
		PH_SZ_FMT,
		PH_SZ_DATA,
		PH_SZ_OTHER,
		PH_FMT,
		PH_EXT,
		PH_SKIP,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic        go;
		logic [31:0] dividend;
		logic [29:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/whp_if.sv =====
interface whp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_end;

	modport source (output valid, output data_byte, output stream_end, input ready);
	modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

interface whp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] format_code;
	logic [15:0] num_channels;
	logic [31:0] sample_rate;
	logic [15:0] bits_per_sample;
	logic [31:0] num_samples;

	modport source (output valid, output status, output format_code, output num_channels,
		output sample_rate, output bits_per_sample, output num_samples, input ready);
	modport sink (input valid, input status, input format_code, input num_channels,
		input sample_rate, input bits_per_sample, input num_samples, output ready);
endinterface

// ===== rtl/wave_header_parser.sv =====
// Timing: a result is registered and leaves in the cycle after the byte that decides it;
//   a clean header (data chunk found) first waits for the serial sample count division.
// Throughput: one file byte per cycle through the header; input is held off while the
//   serial divider runs (32 steps, one quotient bit each, then the quotient hand-over) and
//   while a result waits. Reset: arst_n clears the parser to the start-of-file state;
//   a byte flagged stream_end does the same as it is taken; its result, if any, is still issued.
module wave_header_parser (
	input logic       clk,
	input logic       arst_n,
	whp_in_if.sink    byte_ch,
	whp_out_if.source result_ch
);
	import whp_pkg::*;

	// parse state
	phase_t      phase_q, phase_d;
	logic [4:0]  cnt_q, cnt_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] riff_q, riff_d;
	logic [31:0] sub_q, sub_d;
	logic [15:0] fmt_q, fmt_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;

	// result register
	logic        out_valid_q;
	status_t     out_status_q;
	logic [15:0] out_fmt_q;
	logic [15:0] out_chan_q;
	logic [31:0] out_rate_q;
	logic [15:0] out_bits_q;
	logic [31:0] out_ns_q;

	logic        in_acc;
	logic        last;
	logic [31:0] be;
	logic [31:0] le;
	logic [31:0] rr_dec;
	logic [31:0] sr_dec;
	logic        res_hit;
	status_t     res_st;
	logic        div_go;
	logic        wipe;
	logic        zero_frame;
	logic [13:0] bytes_ps;
	logic [29:0] frame;

	div_req_t dreq;
	div_rsp_t drsp;

	assign in_acc = byte_ch.valid && byte_ch.ready;
	assign last   = byte_ch.stream_end;

	// busy while dividing, while the quotient is handed over, or while a result
	// sits unclaimed
	assign byte_ch.ready = !drsp.busy && !drsp.done && !out_valid_q;

	// big-endian tags shift in from the right, little-endian fields from the left
	assign be = {shift_q[23:0], byte_ch.data_byte};
	assign le = {byte_ch.data_byte, shift_q[31:8]};

	// every byte after the RIFF size counts against the RIFF length, floored at zero
	assign rr_dec = (phase_q != PH_RIFF && phase_q != PH_RSIZE && riff_q != '0) ?
		riff_q - 32'd1 : riff_q;
	assign sr_dec = ((phase_q == PH_FMT || phase_q == PH_EXT || phase_q == PH_SKIP) &&
		sub_q != '0) ? sub_q - 32'd1 : sub_q;

	// bytes per sample times channels; zero only when either factor is zero
	assign bytes_ps   = 14'(({1'b0, bits_q} + 17'd7) >> 3);
	assign zero_frame = (bits_q == '0) || (chan_q == '0);
	assign frame      = 30'(bytes_ps * chan_q);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		shift_d = shift_q;
		riff_d  = riff_q;
		sub_d   = sub_q;
		fmt_d   = fmt_q;
		chan_d  = chan_q;
		rate_d  = rate_q;
		bits_d  = bits_q;
		res_hit = 1'b0;
		res_st  = ST_OK;
		div_go  = 1'b0;
		wipe    = 1'b0;

		if (in_acc) begin
			if (phase_q == PH_DONE) begin
				// trailing bytes ignored until end of file
				wipe = last;
			end else begin
				riff_d = rr_dec;
				sub_d  = sr_dec;
				unique case (phase_q)
					PH_RIFF, PH_WAVE, PH_CID: begin
						shift_d = be;
						cnt_d   = cnt_q + 5'd1;
						if (cnt_q >= 5'd3) begin
							cnt_d = '0;
							priority if (phase_q == PH_RIFF) begin
								if (be != TAG_RIFF) begin
									res_hit = 1'b1;
									res_st  = ST_NOT_RIFF;
								end else begin
									phase_d = PH_RSIZE;
								end
							end else if (phase_q == PH_WAVE) begin
								if (be != TAG_WAVE) begin
									res_hit = 1'b1;
									res_st  = ST_NOT_WAVE;
								end else if (rr_dec == '0) begin
									res_hit = 1'b1;
									res_st  = ST_NO_DATA;
								end else begin
									phase_d = PH_CID;
								end
							end else if (be == TAG_FMT) begin
								phase_d = PH_SZ_FMT;
							end else if (be == TAG_DATA) begin
								phase_d = PH_SZ_DATA;
							end else begin
								phase_d = PH_SZ_OTHER;
							end
						end
					end
					PH_RSIZE, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
						shift_d = le;
						cnt_d   = cnt_q + 5'd1;
						if (cnt_q >= 5'd3) begin
							cnt_d = '0;
							priority if (phase_q == PH_RSIZE) begin
								riff_d  = le;
								phase_d = PH_WAVE;
							end else if (phase_q == PH_SZ_FMT) begin
								sub_d   = le;
								phase_d = PH_FMT;
							end else if (phase_q == PH_SZ_DATA) begin
								sub_d = '0;
								if (le != '0) begin
									res_hit = 1'b1;
									if (zero_frame) begin
										res_st = ST_ZERO_FRAME;
									end else begin
										res_st = ST_OK;
										div_go = 1'b1;
									end
								end else if (rr_dec == '0) begin
									// empty data chunk at the end of the RIFF body
									res_hit = 1'b1;
									res_st  = ST_NO_DATA;
								end else begin
									phase_d = PH_CID;
								end
							end else begin
								sub_d = le;
								if (le != '0) begin
									phase_d = PH_SKIP;
								end else if (rr_dec == '0) begin
									res_hit = 1'b1;
									res_st  = ST_NO_DATA;
								end else begin
									phase_d = PH_CID;
								end
							end
						end
					end
					PH_FMT: begin
						shift_d = le;
						cnt_d   = cnt_q + 5'd1;
						priority if (cnt_q == 5'd1) begin
							fmt_d = le[31:16];
						end else if (cnt_q == 5'd3) begin
							chan_d = le[31:16];
						end else if (cnt_q == 5'd7) begin
							rate_d = le;
						end else if (cnt_q >= 5'd15) begin
							bits_d = le[31:16];
							cnt_d  = '0;
							if (fmt_q == FMT_EXT && sr_dec > EXT_MIN_LEFT) begin
								phase_d = PH_EXT;
							end else if (fmt_q != FMT_PCM && fmt_q != FMT_FLOAT) begin
								res_hit = 1'b1;
								res_st  = ST_BAD_FORMAT;
							end else if (sr_dec != '0) begin
								phase_d = PH_SKIP;
							end else if (rr_dec == '0) begin
								res_hit = 1'b1;
								res_st  = ST_NO_DATA;
							end else begin
								phase_d = PH_CID;
							end
						end else begin
						end
					end
					PH_EXT: begin
						shift_d = le;
						cnt_d   = cnt_q + 5'd1;
						priority if (cnt_q == 5'd3) begin
							// valid bits replace the container size
							bits_d = le[31:16];
						end else if (cnt_q >= 5'd9) begin
							fmt_d = le[31:16];
							cnt_d = '0;
							if (le[31:16] != FMT_PCM && le[31:16] != FMT_FLOAT) begin
								res_hit = 1'b1;
								res_st  = ST_BAD_FORMAT;
							end else if (sr_dec != '0) begin
								phase_d = PH_SKIP;
							end else if (rr_dec == '0) begin
								res_hit = 1'b1;
								res_st  = ST_NO_DATA;
							end else begin
								phase_d = PH_CID;
							end
						end else begin
						end
					end
					PH_SKIP: begin
						if (sr_dec == '0) begin
							cnt_d = '0;
							if (rr_dec == '0) begin
								res_hit = 1'b1;
								res_st  = ST_NO_DATA;
							end else begin
								phase_d = PH_CID;
							end
						end
					end
					default: begin
					end
				endcase

				if (!res_hit && last) begin
					res_hit = 1'b1;
					res_st  = ST_TRUNCATED;
				end
				if (res_hit) begin
					if (last) begin
						wipe = 1'b1;
					end else begin
						phase_d = PH_DONE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
		end else if (wipe) begin
			phase_q <= PH_RIFF;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			shift_q <= '0;
			riff_q  <= '0;
			sub_q   <= '0;
			fmt_q   <= '0;
			chan_q  <= DEF_CHANNELS;
			rate_q  <= DEF_RATE;
			bits_q  <= DEF_BITS;
		end else if (wipe) begin
			cnt_q   <= '0;
			shift_q <= '0;
			riff_q  <= '0;
			sub_q   <= '0;
			fmt_q   <= '0;
			chan_q  <= DEF_CHANNELS;
			rate_q  <= DEF_RATE;
			bits_q  <= DEF_BITS;
		end else begin
			cnt_q   <= cnt_d;
			shift_q <= shift_d;
			riff_q  <= riff_d;
			sub_q   <= sub_d;
			fmt_q   <= fmt_d;
			chan_q  <= chan_d;
			rate_q  <= rate_d;
			bits_q  <= bits_d;
		end
	end

	// sample count: data length over frame size, one bit per cycle
	assign dreq.go       = div_go;
	assign dreq.dividend = le;
	assign dreq.divisor  = frame;

	whp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// result word: fields as parsed up to and including the deciding byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_hit && !div_go) begin
			out_valid_q <= 1'b1;
		end else if (drsp.done) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_hit) begin
			out_status_q <= res_st;
			out_fmt_q    <= fmt_d;
			out_chan_q   <= chan_d;
			out_rate_q   <= rate_d;
			out_bits_q   <= bits_d;
			out_ns_q     <= '0;
		end else if (drsp.done) begin
			out_ns_q <= drsp.quotient;
		end
	end

	assign result_ch.valid           = out_valid_q;
	assign result_ch.status          = out_status_q;
	assign result_ch.format_code     = out_fmt_q;
	assign result_ch.num_channels    = out_chan_q;
	assign result_ch.sample_rate     = out_rate_q;
	assign result_ch.bits_per_sample = out_bits_q;
	assign result_ch.num_samples     = out_ns_q;

`ifndef NO_ASSERTIONS
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(in_acc) || $past(drsp.done)))
		else $error("result appeared without a deciding word or divide");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> (!drsp.busy && !out_valid_q))
		else $error("divide started while busy");

	a_end_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last) |=> (phase_q == PH_RIFF && cnt_q == '0))
		else $error("parser not rewound after end of file");

	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |=> (out_valid_q && out_status_q == ST_OK))
		else $error("divide finished without a clean result");
`endif

endmodule

// ===== rtl/whp_div.sv =====
module whp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  whp_pkg::div_req_t req,
	output whp_pkg::div_rsp_t rsp
);
	import whp_pkg::*;

	localparam int unsigned CW = $clog2(DIV_STEPS);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [29:0]   rem_q;
	logic [31:0]   quo_q;
	logic [29:0]   dvs_q;

	logic [30:0] trial;
	logic        fits;
	logic [29:0] diff;

	// one restoring step per cycle; when it fits the difference is below the divisor
	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial[29:0] - dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff : trial[29:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
